>>> rtl/core/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types and constants of the blit packet decoder: field widths, packet
// form words, status codes, queue job and result layouts.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam int RING_WORDS_DEF = 16384;
    localparam int PACKET_WORDS   = 16;

    localparam int IDX_W      = 14;
    localparam int WORD_W     = 32;
    localparam int COORD_W    = 13;
    localparam int STRIDE_W   = 15;
    localparam int CNT_W      = $clog2(PACKET_WORDS);
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [WORD_W-1:0] HDR_WORD     = 32'hf000_0000;
    localparam logic [WORD_W-1:0] END_WORD     = 32'h7000_0000;
    localparam logic [WORD_W-1:0] W2_FORM_MASK = 32'hffff_8000;
    localparam logic [WORD_W-1:0] W2_FORM_VAL  = 32'h9406_0000;
    localparam logic [WORD_W-1:0] W4_FORM_MASK = 32'hf800_2000;
    localparam logic [WORD_W-1:0] W4_FORM_VAL  = 32'h3000_0000;
    localparam logic [WORD_W-1:0] W5_VAL       = 32'h6080_0200;
    localparam logic [WORD_W-1:0] W6_VAL       = 32'h8000_cccc;
    localparam logic [WORD_W-1:0] W7_VAL       = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] COORD_MASK   = 32'h1fff_1fff;

    localparam logic [COORD_W-1:0]  SURF_W_RST = 13'd320;
    localparam logic [COORD_W-1:0]  SURF_H_RST = 13'd480;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 15'd1280;

    localparam logic [CFG_IDX_W-1:0] CFG_SURF_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

    typedef enum logic [2:0] {
        STS_NONE,
        STS_OK,
        STS_BAD_FORM,
        STS_BAD_TERM,
        STS_EMPTY,
        STS_OUTSIDE,
        STS_UNALIGNED
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DRAIN,
        BK_EVAL
    } back_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]  surface_width;
        logic [COORD_W-1:0]  surface_height;
        logic [STRIDE_W-1:0] row_stride;
    } cfg_t;

    typedef struct packed {
        logic             trig;
        logic [IDX_W-1:0] base;
    } job_t;

    typedef struct packed {
        logic en;
        logic last;
    } rd_req_t;

    typedef struct packed {
        status_t             status_code;
        logic [WORD_W-1:0]   dst_base;
        logic [WORD_W-1:0]   src_base;
        logic [COORD_W-1:0]  src_x;
        logic [COORD_W-1:0]  src_y;
        logic [COORD_W-1:0]  dst_x;
        logic [COORD_W-1:0]  dst_y;
        logic [COORD_W-1:0]  rect_width;
        logic [COORD_W-1:0]  rect_height;
    } result_t;

endpackage

>>> rtl/core/bpd_front.sv
// ----------------------------------------------------------------------------
// bpd_front
// Accepts ring writes, stores them in the command ring, flags packet triggers
// and queues one job per item. Owns the ring memory and its clearing sweep.
// ----------------------------------------------------------------------------
module bpd_front #(
    parameter int RING_WORDS = bpd_pkg::RING_WORDS_DEF,
    localparam int AW = $clog2(RING_WORDS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bpd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           q_full,
    output logic                           push,
    output bpd_pkg::job_t                  push_job,
    input  bpd_pkg::rd_req_t               rd_req,
    input  logic [AW-1:0]                  rd_addr,
    output logic [bpd_pkg::WORD_W-1:0]     rd_data
);

    localparam logic [bpd_pkg::IDX_W+2:0] RING_LIMIT = (bpd_pkg::IDX_W+3)'(RING_WORDS);
    localparam logic [AW-1:0]             LAST_ADDR  = AW'(RING_WORDS - 1);
    localparam logic [bpd_pkg::IDX_W-1:0] TRIG_MIN   =
        bpd_pkg::IDX_W'(bpd_pkg::PACKET_WORDS - 1);

    logic [bpd_pkg::WORD_W-1:0] ring_mem [RING_WORDS];
    logic [bpd_pkg::WORD_W-1:0] rd_data_reg;

    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          hold_reg, hold_next;

    logic [bpd_pkg::IDX_W-1:0]  word_index;
    logic [bpd_pkg::WORD_W-1:0] word_value;
    logic                       in_range;
    logic                       trig;
    logic                       accept;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [bpd_pkg::WORD_W-1:0] wr_data;

    assign word_index = s_tdata[bpd_pkg::IDX_W-1:0];
    assign word_value = s_tdata[bpd_pkg::IDX_W +: bpd_pkg::WORD_W];
    assign in_range   = {3'b000, word_index} < RING_LIMIT;
    assign trig       = in_range && (word_value == bpd_pkg::END_WORD) &&
                        (word_index >= TRIG_MIN);

    // no writes while a triggered packet is still being read out
    assign s_tready = !clr_busy_reg && !q_full && !hold_reg;
    assign accept   = s_tvalid && s_tready;

    assign push          = accept;
    assign push_job.trig = trig;
    assign push_job.base = word_index - TRIG_MIN;

    assign wr_en   = clr_busy_reg || (accept && in_range);
    assign wr_addr = clr_busy_reg ? clr_addr_reg : AW'(word_index);
    assign wr_data = clr_busy_reg ? '0 : word_value;
    assign rd_data = rd_data_reg;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        hold_next = hold_reg;
        if (accept && trig)
        begin
            hold_next = 1'b1;
        end
        else if (rd_req.last)
        begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            hold_reg     <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            hold_reg     <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_req.en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/bpd_queue.sv
// ----------------------------------------------------------------------------
// bpd_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bpd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bpd_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output bpd_pkg::job_t  q_job
);

    bpd_pkg::job_t                entry_reg [bpd_pkg::Q_DEPTH];
    logic [bpd_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bpd_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bpd_pkg::Q_PTR_W:0]    count_reg, count_next;

    assign full    = count_reg == (bpd_pkg::Q_PTR_W+1)'(bpd_pkg::Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/bpd_back.sv
// ----------------------------------------------------------------------------
// bpd_back
// Takes jobs from the queue. A trigger job reads the sixteen packet words one
// a cycle, checks each as it arrives, then grades the rectangle and loads the
// output register.
// ----------------------------------------------------------------------------
module bpd_back #(
    parameter int RING_WORDS = bpd_pkg::RING_WORDS_DEF,
    localparam int AW = $clog2(RING_WORDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpd_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  bpd_pkg::job_t               q_job,
    output logic                        pop,
    output bpd_pkg::rd_req_t            rd_req,
    output logic [AW-1:0]               rd_addr,
    input  logic [bpd_pkg::WORD_W-1:0]  rd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output bpd_pkg::result_t            m_result
);

    localparam int CW = bpd_pkg::COORD_W;
    localparam logic [bpd_pkg::CNT_W-1:0] CNT_LAST = bpd_pkg::CNT_W'(bpd_pkg::PACKET_WORDS - 1);

    bpd_pkg::back_state_t state_reg, state_next;

    logic [bpd_pkg::CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0]             base_reg;
    logic                      dat_vld_reg;
    logic [bpd_pkg::CNT_W-1:0] dat_idx_reg;
    logic                      out_valid_reg, out_valid_next;
    bpd_pkg::result_t          out_res_reg;

    logic                       hdr_ok_reg, form_ok_reg, term_ok_reg, align_ok_reg;
    logic [bpd_pkg::WORD_W-1:0] dst_base_reg, src_base_reg;
    logic [CW-1:0]              sx_reg, sy_reg, dx_reg, dy_reg, dx1_reg, dy1_reg;

    logic             out_free;
    logic             start;
    logic             load_zero;
    logic             load_eval;
    logic             word_ok;
    logic [CW-1:0]    wd, ht, sw_rem, sh_rem;
    logic             outside;
    bpd_pkg::result_t eval_res;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_result = out_res_reg;
    assign rd_addr  = base_reg + AW'(rd_cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpd_pkg::BK_IDLE:
            begin
                if (q_valid && q_job.trig)
                begin
                    state_next = bpd_pkg::BK_READ;
                end
            end
            bpd_pkg::BK_READ:
            begin
                if (rd_cnt_reg == CNT_LAST)
                begin
                    state_next = bpd_pkg::BK_DRAIN;
                end
            end
            bpd_pkg::BK_DRAIN:
            begin
                state_next = bpd_pkg::BK_EVAL;
            end
            bpd_pkg::BK_EVAL:
            begin
                if (out_free)
                begin
                    state_next = bpd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bpd_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop         = 1'b0;
        start       = 1'b0;
        load_zero   = 1'b0;
        load_eval   = 1'b0;
        rd_req.en   = 1'b0;
        rd_req.last = 1'b0;
        unique case (state_reg)
            bpd_pkg::BK_IDLE:
            begin
                pop       = q_valid && (q_job.trig || out_free);
                start     = q_valid && q_job.trig;
                load_zero = q_valid && !q_job.trig && out_free;
            end
            bpd_pkg::BK_READ:
            begin
                rd_req.en   = 1'b1;
                rd_req.last = rd_cnt_reg == CNT_LAST;
            end
            bpd_pkg::BK_DRAIN:
            begin
            end
            bpd_pkg::BK_EVAL:
            begin
                load_eval = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        if (start)
        begin
            rd_cnt_next = '0;
        end
        else if (rd_req.en)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (load_zero || load_eval)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpd_pkg::BK_IDLE;
            rd_cnt_reg    <= '0;
            dat_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            dat_vld_reg   <= rd_req.en;
            out_valid_reg <= out_valid_next;
        end
    end

    // per-word form check
    always_comb
    begin
        word_ok = 1'b1;
        case (dat_idx_reg)
            4'd2:
                word_ok = ((rd_data & bpd_pkg::W2_FORM_MASK) == bpd_pkg::W2_FORM_VAL) &&
                          (rd_data[bpd_pkg::STRIDE_W-1:0] == cfg.row_stride);
            4'd4:
                word_ok = (rd_data & bpd_pkg::W4_FORM_MASK) == bpd_pkg::W4_FORM_VAL;
            4'd5:    word_ok = rd_data == bpd_pkg::W5_VAL;
            4'd6:    word_ok = rd_data == bpd_pkg::W6_VAL;
            4'd7:    word_ok = rd_data == bpd_pkg::W7_VAL;
            4'd8, 4'd9:
                word_ok = (rd_data & ~bpd_pkg::COORD_MASK) == '0;
            default: word_ok = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dat_idx_reg <= rd_cnt_reg;
        if (start)
        begin
            base_reg    <= AW'(q_job.base);
            form_ok_reg <= 1'b1;
            term_ok_reg <= 1'b1;
        end
        else if (dat_vld_reg)
        begin
            form_ok_reg <= form_ok_reg && word_ok;
            if (dat_idx_reg >= 4'd10)
            begin
                term_ok_reg <= term_ok_reg && (rd_data == bpd_pkg::END_WORD);
            end
            case (dat_idx_reg)
                4'd0: hdr_ok_reg <= rd_data == bpd_pkg::HDR_WORD;
                4'd1:
                begin
                    dst_base_reg <= rd_data;
                    align_ok_reg <= rd_data[1:0] == 2'b00;
                end
                4'd3:
                begin
                    src_base_reg <= rd_data;
                    align_ok_reg <= align_ok_reg && (rd_data[1:0] == 2'b00);
                end
                4'd4:
                begin
                    sx_reg <= rd_data[26:14];
                    sy_reg <= rd_data[12:0];
                end
                4'd8:
                begin
                    dx_reg <= rd_data[28:16];
                    dy_reg <= rd_data[12:0];
                end
                4'd9:
                begin
                    dx1_reg <= rd_data[28:16];
                    dy1_reg <= rd_data[12:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // rectangle grading
    always_comb
    begin
        wd      = (dx1_reg > dx_reg) ? dx1_reg - dx_reg : '0;
        ht      = (dy1_reg > dy_reg) ? dy1_reg - dy_reg : '0;
        sw_rem  = cfg.surface_width - sx_reg;
        sh_rem  = cfg.surface_height - sy_reg;
        outside = (dx1_reg > cfg.surface_width) || (dy1_reg > cfg.surface_height) ||
                  (sx_reg > cfg.surface_width) || (wd > sw_rem) ||
                  (sy_reg > cfg.surface_height) || (ht > sh_rem);

        eval_res.dst_base    = dst_base_reg;
        eval_res.src_base    = src_base_reg;
        eval_res.src_x       = sx_reg;
        eval_res.src_y       = sy_reg;
        eval_res.dst_x       = dx_reg;
        eval_res.dst_y       = dy_reg;
        eval_res.rect_width  = wd;
        eval_res.rect_height = ht;

        if (!form_ok_reg)
        begin
            eval_res.status_code = bpd_pkg::STS_BAD_FORM;
        end
        else if (!term_ok_reg)
        begin
            eval_res.status_code = bpd_pkg::STS_BAD_TERM;
        end
        else if ((dx1_reg <= dx_reg) || (dy1_reg <= dy_reg))
        begin
            eval_res.status_code = bpd_pkg::STS_EMPTY;
        end
        else if (outside)
        begin
            eval_res.status_code = bpd_pkg::STS_OUTSIDE;
        end
        else if (!align_ok_reg)
        begin
            eval_res.status_code = bpd_pkg::STS_UNALIGNED;
        end
        else
        begin
            eval_res.status_code = bpd_pkg::STS_OK;
        end

        // no header at the packet start: nothing decoded
        if (!hdr_ok_reg)
        begin
            eval_res = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_zero)
        begin
            out_res_reg <= '0;
        end
        else if (load_eval)
        begin
            out_res_reg <= eval_res;
        end
    end

endmodule

>>> rtl/core/blit_packet_decoder.sv
// ----------------------------------------------------------------------------
// blit_packet_decoder
// Results: a plain write that is taken yields an all-zero result; a write that
// closes a packet yields its graded result once the 16 words are read.
// Throughput: one plain write per cycle while m_tready is high; a closing write
// keeps s_tready low until the ring read, one word a cycle, takes the last word.
// Reset: async, active low; afterwards the ring is swept to zero, one word a
// cycle over all RING_WORDS words, with s_tready low (cfg writes still taken).
// ----------------------------------------------------------------------------
module blit_packet_decoder #(
    parameter int RING_WORDS = bpd_pkg::RING_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // word_index[13:0], word_value[45:14], zero pad
    input  logic [bpd_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status_code[2:0], dst_base[34:3], src_base[66:35], src_x[79:67],
    // src_y[92:80], dst_x[105:93], dst_y[118:106], rect_width[131:119],
    // rect_height[144:132], zero pad
    output logic [bpd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(RING_WORDS);

    bpd_pkg::cfg_t    cfg_reg, cfg_next;
    logic             q_full;
    logic             push;
    bpd_pkg::job_t    push_job;
    logic             pop;
    logic             q_valid;
    bpd_pkg::job_t    q_job;
    bpd_pkg::rd_req_t rd_req;
    logic [AW-1:0]    rd_addr;
    logic [bpd_pkg::WORD_W-1:0] rd_data;
    bpd_pkg::result_t m_result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bpd_pkg::CFG_SURF_W:
                    cfg_next.surface_width  = cfg_data[bpd_pkg::COORD_W-1:0];
                bpd_pkg::CFG_SURF_H:
                    cfg_next.surface_height = cfg_data[bpd_pkg::COORD_W-1:0];
                bpd_pkg::CFG_STRIDE:
                    cfg_next.row_stride     = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_width  <= bpd_pkg::SURF_W_RST;
            cfg_reg.surface_height <= bpd_pkg::SURF_H_RST;
            cfg_reg.row_stride     <= bpd_pkg::STRIDE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpd_front #(
        .RING_WORDS (RING_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job),
        .rd_req   (rd_req),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    bpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    bpd_back #(
        .RING_WORDS (RING_WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop),
        .rd_req   (rd_req),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {7'b0000000,
                      m_result.rect_height,
                      m_result.rect_width,
                      m_result.dst_y,
                      m_result.dst_x,
                      m_result.src_y,
                      m_result.src_x,
                      m_result.src_base,
                      m_result.dst_base,
                      m_result.status_code};

endmodule

>>> rtl/core/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks on the blit packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bpd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bpd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam logic [2:0] STS_NONE_C = 3'(bpd_pkg::STS_NONE);
    localparam logic [2:0] STS_OK_C   = 3'(bpd_pkg::STS_OK);
    localparam logic [2:0] STS_MAX_C  = 3'(bpd_pkg::STS_UNALIGNED);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= STS_MAX_C)
        else $error("status code out of range");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == STS_NONE_C) |-> m_tdata[151:3] == '0)
        else $error("no-packet result carries data");

    a_ok_rect: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == STS_OK_C) |->
            (m_tdata[131:119] != '0) && (m_tdata[144:132] != '0))
        else $error("accepted packet with empty rectangle");

    // ring sweep keeps input closed right after reset
    a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_tready)
        else $error("input open during ring clear");

endmodule

bind blit_packet_decoder bpd_checker u_bpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
